// ===== rtl/tts_pkg.sv =====
// Shared types, constants and fixed-point helpers for the tridiagonal Toeplitz solver.
// Used by the solver top level; depends on nothing else.
package tts_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAX_ORDER = 64;
    localparam int ADDR_W    = $clog2(MAX_ORDER);
    localparam int ORD_W     = ADDR_W + 1;
    localparam int QUO_W     = DATA_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int CFG_W     = 2;

    localparam logic [CFG_W-1:0] CFG_SUB   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_DIAG  = 2'd1;
    localparam logic [CFG_W-1:0] CFG_SUPER = 2'd2;
    localparam logic [CFG_W-1:0] CFG_ORDER = 2'd3;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_R_RD,
        ST_R_M1,
        ST_R_S1,
        ST_R_S2,
        ST_DIV,
        ST_DRUN,
        ST_DFIN,
        ST_R_WB,
        ST_S_M1,
        ST_S_M2,
        ST_S_M3,
        ST_S_M4,
        ST_S_M5,
        ST_S_WB,
        ST_X_RD,
        ST_X_M,
        ST_X_W,
        ST_E_RD,
        ST_E_LD
    } t_state;

    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] val;
    } t_sat;

    function automatic t_sat sat_wide(input logic signed [DATA_W+1:0] x);
        t_sat r;
        if (x > $signed({3'b000, {(DATA_W-1){1'b1}}})) begin
            r.ovf = 1'b1;
            r.val = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (x < $signed({3'b111, {(DATA_W-1){1'b0}}})) begin
            r.ovf = 1'b1;
            r.val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r.ovf = 1'b0;
            r.val = x[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic t_sat add_sat(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        logic signed [DATA_W+1:0] s;
        s = $signed({{2{a[DATA_W-1]}}, a}) + $signed({{2{b[DATA_W-1]}}, b});
        return sat_wide(s);
    endfunction

    function automatic t_sat sub_sat(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        logic signed [DATA_W+1:0] s;
        s = $signed({{2{a[DATA_W-1]}}, a}) - $signed({{2{b[DATA_W-1]}}, b});
        return sat_wide(s);
    endfunction

    function automatic t_sat mul_round(input logic signed [2*DATA_W-1:0] p);
        logic signed [2*DATA_W-1:0] t;
        logic signed [2*DATA_W-1:0] s;
        t_sat r;
        t = p + ($signed({{(2*DATA_W-1){1'b0}}, 1'b1}) <<< (FRAC_BITS - 1));
        s = t >>> FRAC_BITS;
        if (s > $signed({{(DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}})) begin
            r.ovf = 1'b1;
            r.val = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (s < $signed({{(DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}})) begin
            r.ovf = 1'b1;
            r.val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r.ovf = 1'b0;
            r.val = s[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/toeplitz_tridiagonal_solve.sv =====
// Tridiagonal Toeplitz solver: loads n right-hand-side values, then solves and emits x[0..n-1].
// Input transactions are taken one per cycle until the n-th; the solve then runs, per row, a
// particular and a homogeneous step, each with a 48-step bit-serial divide, then solves the
// last unknown, applies one correction per row and emits the results in index order.
// Synchronous active-low reset clears control state and loads default coefficients; the stores
// hold no defined value until written. Depends on tts_pkg and tts_ram.
module toeplitz_tridiagonal_solve (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tts_pkg::CFG_W-1:0]     i_cfg_index,
    input  logic [tts_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                          i_rhs_valid,
    output logic                          o_rhs_ready,
    input  logic signed [tts_pkg::DATA_W-1:0] i_rhs_value,
    output logic                          o_sol_valid,
    input  logic                          i_sol_ready,
    output logic signed [tts_pkg::DATA_W-1:0] o_solution_value,
    output logic [tts_pkg::ADDR_W-1:0]    o_solution_index,
    output logic                          o_last_result,
    output logic                          o_fault
);

    localparam int DW = tts_pkg::DATA_W;
    localparam int AW = tts_pkg::ADDR_W;
    localparam int OW = tts_pkg::ORD_W;
    localparam int QW = tts_pkg::QUO_W;
    localparam int CW = tts_pkg::CNT_W;

    tts_pkg::t_state r_state, n_state, r_dret;

    logic [DW-1:0] r_sub, r_diag, r_super;
    logic [OW-1:0] r_order, r_n, n_eff;
    logic [AW-1:0] r_load_cnt, r_idx;
    logic          r_hsel, r_fault;
    logic [DW-1:0] r_p1, r_p2, r_h1, r_h2, r_acc, r_tmp, r_dden, r_q, r_s;
    logic signed [2*DW-1:0] r_prod;
    logic [DW-1:0] r_rem, r_dvs;
    logic [QW-1:0] r_quo;
    logic [CW-1:0] r_dcnt;
    logic          r_neg;
    logic          r_ovalid;
    logic [DW-1:0] r_oval;
    logic [AW-1:0] r_oidx;
    logic          r_olast, r_ofault;

    logic          in_acc, load_done, out_free, idx_last_row, idx_last_out;
    logic [OW-1:0] n_minus2;
    logic [DW-1:0] coef_c, abs_num, abs_den;
    logic [DW:0]   div_sh, div_trial;
    logic [QW-1:0] quo_max_pos, quo_max_neg;

    logic          rhs_we, p_we, h_we;
    logic [AW-1:0] rhs_raddr, p_waddr;
    logic [DW-1:0] rhs_rdata, p_rdata, h_rdata, p_wdata;

    tts_pkg::t_sat mr, sr, sr2;

    always_comb begin
        if (r_order < OW'(3)) begin
            n_eff = OW'(3);
        end else if (r_order > OW'(tts_pkg::MAX_ORDER)) begin
            n_eff = OW'(tts_pkg::MAX_ORDER);
        end else begin
            n_eff = r_order;
        end
    end

    assign in_acc       = i_rhs_valid && o_rhs_ready;
    assign load_done    = ({1'b0, r_load_cnt} + OW'(1)) >= n_eff;
    assign out_free     = !r_ovalid || i_sol_ready;
    assign n_minus2     = r_n - OW'(2);
    assign idx_last_row = {1'b0, r_idx} == n_minus2;
    assign idx_last_out = {1'b0, r_idx} == (r_n - OW'(1));
    assign div_sh       = {r_rem, r_quo[QW-1]};
    assign div_trial    = div_sh - {1'b0, r_dvs};
    assign abs_num      = r_acc[DW-1] ? (~r_acc + DW'(1)) : r_acc;
    assign abs_den      = r_dden[DW-1] ? (~r_dden + DW'(1)) : r_dden;
    assign quo_max_pos  = {{(QW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    assign quo_max_neg  = {{(QW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

    always_comb begin
        if (idx_last_row) begin
            coef_c = r_diag;
        end else if ({1'b0, r_idx} == (r_n - OW'(3))) begin
            coef_c = r_super;
        end else begin
            coef_c = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tts_pkg::ST_LOAD: if (in_acc && load_done) n_state = tts_pkg::ST_R_RD;
            tts_pkg::ST_R_RD: n_state = tts_pkg::ST_R_M1;
            tts_pkg::ST_R_M1: n_state = tts_pkg::ST_R_S1;
            tts_pkg::ST_R_S1: n_state = tts_pkg::ST_R_S2;
            tts_pkg::ST_R_S2: n_state = tts_pkg::ST_DIV;
            tts_pkg::ST_DIV:  n_state = (r_dden == '0) ? r_dret : tts_pkg::ST_DRUN;
            tts_pkg::ST_DRUN: if (r_dcnt == CW'(QW - 1)) n_state = tts_pkg::ST_DFIN;
            tts_pkg::ST_DFIN: n_state = r_dret;
            tts_pkg::ST_R_WB: begin
                if (!r_hsel) begin
                    n_state = tts_pkg::ST_R_M1;
                end else if (r_idx == '0) begin
                    n_state = tts_pkg::ST_S_M1;
                end else begin
                    n_state = tts_pkg::ST_R_RD;
                end
            end
            tts_pkg::ST_S_M1: n_state = tts_pkg::ST_S_M2;
            tts_pkg::ST_S_M2: n_state = tts_pkg::ST_S_M3;
            tts_pkg::ST_S_M3: n_state = tts_pkg::ST_S_M4;
            tts_pkg::ST_S_M4: n_state = tts_pkg::ST_S_M5;
            tts_pkg::ST_S_M5: n_state = tts_pkg::ST_DIV;
            tts_pkg::ST_S_WB: n_state = tts_pkg::ST_X_RD;
            tts_pkg::ST_X_RD: n_state = tts_pkg::ST_X_M;
            tts_pkg::ST_X_M:  n_state = tts_pkg::ST_X_W;
            tts_pkg::ST_X_W:  n_state = idx_last_row ? tts_pkg::ST_E_RD : tts_pkg::ST_X_RD;
            tts_pkg::ST_E_RD: n_state = tts_pkg::ST_E_LD;
            tts_pkg::ST_E_LD: begin
                if (out_free) begin
                    n_state = idx_last_out ? tts_pkg::ST_LOAD : tts_pkg::ST_E_RD;
                end
            end
            default: n_state = tts_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_rhs_ready = 1'b0;
        rhs_we      = 1'b0;
        p_we        = 1'b0;
        h_we        = 1'b0;
        rhs_raddr   = r_idx + AW'(1);
        p_waddr     = r_idx;
        p_wdata     = r_q;
        unique case (r_state)
            tts_pkg::ST_LOAD: begin
                o_rhs_ready = 1'b1;
                rhs_we      = in_acc;
            end
            tts_pkg::ST_R_WB: begin
                p_we = !r_hsel;
                h_we = r_hsel;
            end
            tts_pkg::ST_S_M1: rhs_raddr = '0;
            tts_pkg::ST_X_W: begin
                p_we    = 1'b1;
                p_wdata = sr.val;
            end
            default: ;
        endcase
    end

    always_comb begin
        mr  = tts_pkg::mul_round(r_prod);
        sr  = tts_pkg::sub_sat(r_acc, mr.val);
        sr2 = tts_pkg::add_sat(r_acc, mr.val);
        unique case (r_state)
            tts_pkg::ST_S_M4: sr = tts_pkg::sub_sat(r_acc, r_tmp);
            tts_pkg::ST_S_M5: sr2 = tts_pkg::add_sat(r_tmp, mr.val);
            default: ;
        endcase
    end

    tts_ram #(.WIDTH(DW), .DEPTH(tts_pkg::MAX_ORDER)) u_rhs_ram (
        .i_clk   (i_clk),
        .i_we    (rhs_we),
        .i_waddr (r_load_cnt),
        .i_wdata (i_rhs_value),
        .i_raddr (rhs_raddr),
        .o_rdata (rhs_rdata)
    );

    tts_ram #(.WIDTH(DW), .DEPTH(tts_pkg::MAX_ORDER)) u_part_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (r_idx),
        .o_rdata (p_rdata)
    );

    tts_ram #(.WIDTH(DW), .DEPTH(tts_pkg::MAX_ORDER)) u_homog_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (r_idx),
        .i_wdata (r_q),
        .i_raddr (r_idx),
        .o_rdata (h_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tts_pkg::ST_LOAD;
            r_sub      <= DW'(65536);
            r_diag     <= '0;
            r_super    <= '0;
            r_order    <= OW'(tts_pkg::MAX_ORDER);
            r_load_cnt <= '0;
            r_ovalid   <= 1'b0;
            r_fault    <= 1'b0;
            r_s        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tts_pkg::CFG_SUB:   r_sub   <= i_cfg_data;
                    tts_pkg::CFG_DIAG:  r_diag  <= i_cfg_data;
                    tts_pkg::CFG_SUPER: r_super <= i_cfg_data;
                    tts_pkg::CFG_ORDER: r_order <= i_cfg_data[OW-1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_sol_ready && r_state != tts_pkg::ST_E_LD) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                tts_pkg::ST_LOAD: begin
                    if (in_acc) begin
                        if (load_done) begin
                            r_load_cnt <= '0;
                            r_n        <= n_eff;
                            r_idx      <= AW'(n_eff - OW'(2));
                            r_hsel     <= 1'b0;
                            r_fault    <= 1'b0;
                            r_p1       <= '0;
                            r_p2       <= '0;
                            r_h1       <= '0;
                            r_h2       <= '0;
                        end else begin
                            r_load_cnt <= r_load_cnt + AW'(1);
                        end
                    end
                end
                tts_pkg::ST_R_M1: begin
                    r_acc  <= r_hsel ? coef_c : rhs_rdata;
                    r_prod <= $signed(r_diag) * $signed(r_hsel ? r_h1 : r_p1);
                end
                tts_pkg::ST_R_S1: begin
                    r_acc   <= sr.val;
                    r_fault <= r_fault | mr.ovf | sr.ovf;
                    r_prod  <= $signed(r_super) * $signed(r_hsel ? r_h2 : r_p2);
                end
                tts_pkg::ST_R_S2: begin
                    r_acc   <= sr.val;
                    r_fault <= r_fault | mr.ovf | sr.ovf;
                    r_dden  <= r_sub;
                    r_dret  <= tts_pkg::ST_R_WB;
                end
                tts_pkg::ST_DIV: begin
                    r_rem  <= '0;
                    r_quo  <= {abs_num, {tts_pkg::FRAC_BITS{1'b0}}};
                    r_dvs  <= abs_den;
                    r_neg  <= r_acc[DW-1] ^ r_dden[DW-1];
                    r_dcnt <= '0;
                    if (r_dden == '0) begin
                        r_q     <= '0;
                        r_fault <= 1'b1;
                    end
                end
                tts_pkg::ST_DRUN: begin
                    r_dcnt <= r_dcnt + CW'(1);
                    if (!div_trial[DW]) begin
                        r_rem <= div_trial[DW-1:0];
                        r_quo <= {r_quo[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= div_sh[DW-1:0];
                        r_quo <= {r_quo[QW-2:0], 1'b0};
                    end
                end
                tts_pkg::ST_DFIN: begin
                    if (!r_neg) begin
                        if (r_quo > quo_max_pos) begin
                            r_q     <= {1'b0, {(DW-1){1'b1}}};
                            r_fault <= 1'b1;
                        end else begin
                            r_q <= r_quo[DW-1:0];
                        end
                    end else begin
                        if (r_quo > quo_max_neg) begin
                            r_q     <= {1'b1, {(DW-1){1'b0}}};
                            r_fault <= 1'b1;
                        end else begin
                            r_q <= ~r_quo[DW-1:0] + DW'(1);
                        end
                    end
                end
                tts_pkg::ST_R_WB: begin
                    if (!r_hsel) begin
                        r_p2   <= r_p1;
                        r_p1   <= r_q;
                        r_hsel <= 1'b1;
                    end else begin
                        r_h2   <= r_h1;
                        r_h1   <= r_q;
                        r_hsel <= 1'b0;
                        if (r_idx != '0) begin
                            r_idx <= r_idx - AW'(1);
                        end
                    end
                end
                tts_pkg::ST_S_M1: r_prod <= $signed(r_diag) * $signed(r_p1);
                tts_pkg::ST_S_M2: begin
                    r_acc   <= mr.val;
                    r_fault <= r_fault | mr.ovf;
                    r_tmp   <= rhs_rdata;
                    r_prod  <= $signed(r_super) * $signed(r_p2);
                end
                tts_pkg::ST_S_M3: begin
                    r_acc   <= sr2.val;
                    r_fault <= r_fault | mr.ovf | sr2.ovf;
                    r_prod  <= $signed(r_diag) * $signed(r_h1);
                end
                tts_pkg::ST_S_M4: begin
                    r_acc   <= sr.val;
                    r_tmp   <= mr.val;
                    r_fault <= r_fault | mr.ovf | sr.ovf;
                    r_prod  <= $signed(r_super) * $signed(r_h2);
                end
                tts_pkg::ST_S_M5: begin
                    r_dden  <= sr2.val;
                    r_fault <= r_fault | mr.ovf | sr2.ovf;
                    r_dret  <= tts_pkg::ST_S_WB;
                end
                tts_pkg::ST_S_WB: begin
                    r_s   <= r_q;
                    r_idx <= '0;
                end
                tts_pkg::ST_X_M: begin
                    r_acc  <= p_rdata;
                    r_prod <= $signed(r_s) * $signed(h_rdata);
                end
                tts_pkg::ST_X_W: begin
                    r_fault <= r_fault | mr.ovf | sr.ovf;
                    r_idx   <= idx_last_row ? '0 : r_idx + AW'(1);
                end
                tts_pkg::ST_E_LD: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= idx_last_out ? r_s : p_rdata;
                        r_oidx   <= r_idx;
                        r_olast  <= idx_last_out;
                        r_ofault <= r_fault;
                        r_idx    <= r_idx + AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sol_valid      = r_ovalid;
    assign o_solution_value = r_oval;
    assign o_solution_index = r_oidx;
    assign o_last_result    = r_olast;
    assign o_fault          = r_ofault;

endmodule

// ===== rtl/tts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
